// ===== rtl/pcs_tx_pkg.sv =====
// ----------------------------------------------------------------------------
// PCS transmit package
// Shared types, codes and command decode for the PCS transmit framing block.
// ----------------------------------------------------------------------------
package pcs_tx_pkg;

  // Timer counter width
  localparam int unsigned TimerWidth = 16;
  localparam int unsigned CfgWidth   = 16;

  // MII command nibbles (tx_enable low, tx_error high)
  localparam logic [3:0] NibBeacon = 4'h2;
  localparam logic [3:0] NibCommit = 4'h3;

  typedef enum logic [3:0] {
    KIND_SILENCE = 4'd0,
    KIND_BEACON  = 4'd1,
    KIND_COMMIT  = 4'd2,
    KIND_SYNC    = 4'd3,
    KIND_SSD     = 4'd4,
    KIND_DATA    = 4'd5,
    KIND_ESD     = 4'd6,
    KIND_ESD_BRS = 4'd7,
    KIND_ESD_ERR = 4'd8,
    KIND_ESD_JAB = 4'd9
  } symbol_kind_e;

  typedef enum logic {
    CFG_MAX_FRAME = 1'b0,
    CFG_UNJAB     = 1'b1
  } cfg_index_e;

  // Timer control from the FSM; stop wins over start
  typedef struct packed {
    logic start;
    logic stop;
  } timer_ctrl_t;

  // Beacon / commit / silence from the MII signals
  function automatic symbol_kind_e decode_cmd(logic en, logic er, logic [3:0] nib);
    symbol_kind_e k;
    k = KIND_SILENCE;
    if (!en && er) begin
      if (nib == NibBeacon) k = KIND_BEACON;
      else if (nib == NibCommit) k = KIND_COMMIT;
    end
    return k;
  endfunction

endpackage

// ===== rtl/pcs_tx_timer.sv =====
// ----------------------------------------------------------------------------
// PCS transmit timer
// Saturating up-counter that ticks once per symbol; done when it hits limit.
// ----------------------------------------------------------------------------
module pcs_tx_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [pcs_tx_pkg::CfgWidth-1:0] limit_i,
  input  pcs_tx_pkg::timer_ctrl_t       ctrl_i,
  output logic                          done_o
);
  import pcs_tx_pkg::*;

  localparam int unsigned CmpWidth = (TimerWidth > CfgWidth) ? TimerWidth : CfgWidth;

  logic [TimerWidth-1:0] count_q, count_d, count_tick;
  logic                  running_q, running_d;
  logic [CmpWidth-1:0]   lim_ext, tmax_ext, lim_cap, cnt_ext;

  assign lim_ext  = CmpWidth'(limit_i);
  assign tmax_ext = CmpWidth'({TimerWidth{1'b1}});
  assign lim_cap  = (lim_ext > tmax_ext) ? tmax_ext : lim_ext;
  assign cnt_ext  = CmpWidth'(count_q);

  // Tick happens at the start of the step, before the FSM looks at done
  always_comb begin
    count_tick = count_q;
    if (running_q && (cnt_ext < lim_cap)) count_tick = count_q + 1'b1;
  end

  assign done_o = running_q && (CmpWidth'(count_tick) >= lim_cap);

  always_comb begin
    count_d   = count_q;
    running_d = running_q;
    if (step_i) begin
      if (ctrl_i.stop) begin
        count_d   = '0;
        running_d = 1'b0;
      end else if (ctrl_i.start) begin
        count_d   = '0;
        running_d = 1'b1;
      end else begin
        count_d   = count_tick;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      running_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      running_q <= running_d;
    end
  end

endmodule

// ===== rtl/pcs_tx_fsm.sv =====
// ----------------------------------------------------------------------------
// PCS transmit framing FSM
// One step per symbol tick; state registers double as the result payload.
// ----------------------------------------------------------------------------
module pcs_tx_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      tx_enable_i,
  input  logic                      tx_error_i,
  input  logic [3:0]                tx_nibble_i,
  input  logic                      pcs_reset_i,
  input  logic                      max_done_i,
  input  logic                      unjab_done_i,
  output pcs_tx_pkg::timer_ctrl_t   max_ctrl_o,
  output pcs_tx_pkg::timer_ctrl_t   unjab_ctrl_o,
  output pcs_tx_pkg::symbol_kind_e  symbol_kind_o,
  output logic [3:0]                data_nibble_o,
  output logic                      transmitting_o
);
  import pcs_tx_pkg::*;

  typedef enum logic [3:0] {
    ST_SILENT   = 4'd0,
    ST_COMMIT   = 4'd1,
    ST_SYNC1    = 4'd2,
    ST_SYNC2    = 4'd3,
    ST_SSD1     = 4'd4,
    ST_SSD2     = 4'd5,
    ST_DATA     = 4'd6,
    ST_ESD      = 4'd7,
    ST_BAD_ESD  = 4'd8,
    ST_GOOD_ESD = 4'd9,
    ST_UNJAB    = 4'd10
  } state_e;

  state_e       state_q, state_d, target;
  symbol_kind_e sym_q, sym_d, cmd;
  logic [3:0]   nib_q, nib_d;
  logic         err_q, err_d;
  logic         tx_q, tx_d;
  logic         rst_prev_q, rst_prev_d;
  logic         do_enter;

  assign cmd = decode_cmd(tx_enable_i, tx_error_i, tx_nibble_i);

  // Pick the transition target
  always_comb begin
    target       = ST_SILENT;
    do_enter     = 1'b0;
    rst_prev_d   = rst_prev_q;
    max_ctrl_o   = '0;
    unjab_ctrl_o = '0;
    if (step_i) begin
      if (pcs_reset_i) begin
        if (!rst_prev_q) begin
          rst_prev_d         = 1'b1;
          max_ctrl_o.stop    = 1'b1;
          unjab_ctrl_o.stop  = 1'b1;
          do_enter           = 1'b1;
        end
      end else begin
        rst_prev_d = 1'b0;
        unique case (state_q)
          ST_COMMIT: begin
            if (tx_enable_i) begin
              target = ST_SYNC1; do_enter = 1'b1;
            end else if (cmd == KIND_SILENCE) begin
              target = ST_ESD; do_enter = 1'b1;
            end
          end
          ST_SYNC1: begin
            target = ST_SYNC2; do_enter = 1'b1;
          end
          ST_SYNC2: begin
            target = ST_SSD1; do_enter = 1'b1;
          end
          ST_SSD1: begin
            target = ST_SSD2; do_enter = 1'b1;
          end
          ST_SSD2: begin
            target = ST_DATA; do_enter = 1'b1;
          end
          ST_DATA: begin
            target   = (tx_enable_i && !max_done_i) ? ST_DATA : ST_ESD;
            do_enter = 1'b1;
          end
          ST_ESD: begin
            target   = (err_q || max_done_i) ? ST_BAD_ESD : ST_GOOD_ESD;
            do_enter = 1'b1;
          end
          ST_BAD_ESD: begin
            if (err_q) begin
              target = ST_SILENT; do_enter = 1'b1;
            end else if (max_done_i) begin
              target = ST_UNJAB; do_enter = 1'b1;
            end
          end
          ST_GOOD_ESD: begin
            target = ST_SILENT; do_enter = 1'b1;
          end
          ST_UNJAB: begin
            if (!tx_enable_i && unjab_done_i) begin
              target = ST_SILENT; do_enter = 1'b1;
            end
          end
          default: begin
            do_enter = 1'b1;
            if (tx_enable_i) target = ST_SYNC1;
            else if (cmd == KIND_COMMIT) target = ST_COMMIT;
            else target = ST_SILENT;
          end
        endcase
      end
    end
    // Timer starts on state entry
    if (do_enter && target == ST_SSD2) max_ctrl_o.start = 1'b1;
    if (do_enter && target == ST_UNJAB) unjab_ctrl_o.start = 1'b1;
  end

  // Entry actions
  always_comb begin
    state_d = state_q;
    sym_d   = sym_q;
    nib_d   = nib_q;
    err_d   = err_q;
    tx_d    = tx_q;
    if (do_enter) begin
      state_d = target;
      nib_d   = '0;
      unique case (target)
        ST_COMMIT: sym_d = KIND_COMMIT;
        ST_SYNC1: begin
          tx_d  = 1'b1;
          err_d = err_q | tx_error_i;
          sym_d = KIND_SYNC;
        end
        ST_SYNC2: err_d = err_q | tx_error_i;
        ST_SSD1: begin
          err_d = err_q | tx_error_i;
          sym_d = KIND_SSD;
        end
        ST_SSD2: err_d = err_q | tx_error_i;
        ST_DATA: begin
          err_d = err_q | tx_error_i;
          sym_d = KIND_DATA;
          nib_d = tx_nibble_i;
        end
        ST_ESD:      sym_d = (cmd == KIND_COMMIT) ? KIND_ESD_BRS : KIND_ESD;
        ST_BAD_ESD:  sym_d = err_q ? KIND_ESD_ERR : KIND_ESD_JAB;
        ST_GOOD_ESD: sym_d = KIND_ESD_BRS;
        ST_UNJAB:    sym_d = KIND_SILENCE;
        default: begin
          state_d = ST_SILENT;
          tx_d    = 1'b0;
          err_d   = 1'b0;
          sym_d   = cmd;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SILENT;
      sym_q      <= KIND_SILENCE;
      nib_q      <= '0;
      err_q      <= 1'b0;
      tx_q       <= 1'b0;
      rst_prev_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      sym_q      <= sym_d;
      nib_q      <= nib_d;
      err_q      <= err_d;
      tx_q       <= tx_d;
      rst_prev_q <= rst_prev_d;
    end
  end

  assign symbol_kind_o  = sym_q;
  assign data_nibble_o  = (sym_q == KIND_DATA) ? nib_q : 4'h0;
  assign transmitting_o = tx_q;

endmodule

// ===== rtl/pcs_transmit_symbol_fsm_top.sv =====
// ----------------------------------------------------------------------------
// PCS transmit symbol FSM, top level
// Path: the input register loads on acceptance, and the FSM steps into the
//   result register when that register can advance.
// Throughput: 1 request per cycle while the output is not stalled, set by the
//   single FSM step per tick.
// Reset: rst_ni async active low; FSM silent, timers stopped, both limit
//   registers at 65535, no request held.
// ----------------------------------------------------------------------------
module pcs_transmit_symbol_fsm_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] tx_enable, [1] tx_error,
                                        // [5:2] tx_nibble, [6] pcs_reset, [7] 0
  // Output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [3:0] data_nibble, [4] transmitting,
                                        // [7:5] 0
  output logic [3:0]  m_axis_tuser_o    // [3:0] symbol_kind
);
  import pcs_tx_pkg::*;

  // Limit registers
  logic [CfgWidth-1:0] max_lim_q, unjab_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lim_q   <= '1;
      unjab_lim_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_idx_i))
        CFG_MAX_FRAME: max_lim_q   <= cfg_wdata_i;
        CFG_UNJAB:     unjab_lim_q <= cfg_wdata_i;
      endcase
    end
  end

  // Input register stage. Holds one request while the result register is
  // stalled, so the upstream side sees ready whenever that slot is free.
  logic       in_vld_q;
  logic [6:0] in_data_q;
  logic       in_fire, out_adv, step;
  logic       out_vld_q;

  assign out_adv         = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && out_adv;
  assign s_axis_tready_o = !in_vld_q || out_adv;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (out_adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) in_data_q <= s_axis_tdata_i[6:0];
  end

  // Result valid; the payload is the FSM's symbol/nibble/flag registers,
  // which only change on a step, i.e. when this register loads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  timer_ctrl_t  max_ctrl, unjab_ctrl;
  logic         max_done, unjab_done;
  symbol_kind_e kind;
  logic [3:0]   nibble;
  logic         transmitting;

  pcs_tx_timer u_max_timer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .limit_i (max_lim_q),
    .ctrl_i  (max_ctrl),
    .done_o  (max_done)
  );

  pcs_tx_timer u_unjab_timer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .limit_i (unjab_lim_q),
    .ctrl_i  (unjab_ctrl),
    .done_o  (unjab_done)
  );

  pcs_tx_fsm u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .tx_enable_i    (in_data_q[0]),
    .tx_error_i     (in_data_q[1]),
    .tx_nibble_i    (in_data_q[5:2]),
    .pcs_reset_i    (in_data_q[6]),
    .max_done_i     (max_done),
    .unjab_done_i   (unjab_done),
    .max_ctrl_o     (max_ctrl),
    .unjab_ctrl_o   (unjab_ctrl),
    .symbol_kind_o  (kind),
    .data_nibble_o  (nibble),
    .transmitting_o (transmitting)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'd0, transmitting, nibble};
  assign m_axis_tuser_o  = kind;

  // A nonzero nibble only ever goes out with a data symbol
  a_nibble_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && nibble != 4'h0) |-> (kind == KIND_DATA))
    else $error("data nibble set on non-data symbol");

  // Frame body symbols are always sent while transmitting
  a_body_transmitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (kind == KIND_SYNC || kind == KIND_SSD || kind == KIND_DATA))
    |-> transmitting)
    else $error("frame symbol without transmitting flag");

  // Every FSM step yields a held result in the next cycle
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("FSM step lost its result");

endmodule

// ===== dv/pcs_transmit_symbol_fsm_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCS transmit symbol FSM testbench
// Drives MII symbol ticks into the framer and checks every emitted symbol.
// A short hand-written walk (idle, beacon, commit, clean frame, errored
// frame, PCS reset) runs first. Random frames and noise follow under six
// limit settings, with both stream sides stalling at random.
// ----------------------------------------------------------------------------
module pcs_transmit_symbol_fsm_top_tb;
  import pcs_tx_pkg::*;

  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseTicks  = 275;     // random ticks per setting
  localparam int unsigned SettleWait  = 4;       // pipeline is 2 deep
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned ReportCap   = 50;

  // One MII tick as packed into s_axis_tdata[6:0]
  typedef struct packed {
    logic       pcs_reset;
    logic [3:0] nib;
    logic       er;
    logic       en;
  } tick_t;

  // One expected symbol: kind on tuser, nibble and flag on tdata
  typedef struct packed {
    logic         tx;
    logic [3:0]   nib;
    symbol_kind_e kind;
  } sym_t;

  // Framer states of the predictor
  typedef enum logic [3:0] {
    F_SILENT, F_COMMIT, F_SYNC1, F_SYNC2, F_SSD1, F_SSD2,
    F_DATA, F_ESD, F_BAD_ESD, F_GOOD_ESD, F_UNJAB
  } framer_state_e;

  // Hand-written walk; typed = 1 rows carry their own expected symbol
  typedef struct {
    bit           typed;
    logic         en;
    logic         er;
    logic [3:0]   nib;
    logic         rst;
    symbol_kind_e kind;
    logic [3:0]   dnib;
    logic         tx;
  } walk_row_t;

  walk_row_t walk [25] = '{
    '{1, 0, 0, 4'h0, 0, KIND_SILENCE, 4'h0, 0},   // idle out of reset
    '{1, 0, 1, 4'h2, 0, KIND_BEACON,  4'h0, 0},   // beacon request
    '{1, 0, 1, 4'h3, 0, KIND_COMMIT,  4'h0, 0},   // commit entry
    '{0, 0, 1, 4'h3, 0, KIND_SILENCE, 4'h0, 0},   // commit held
    '{1, 1, 0, 4'hf, 0, KIND_SYNC,    4'h0, 1},   // commit -> sync
    '{0, 1, 0, 4'h0, 0, KIND_SILENCE, 4'h0, 0},
    '{0, 1, 0, 4'h0, 0, KIND_SILENCE, 4'h0, 0},
    '{0, 1, 0, 4'h0, 0, KIND_SILENCE, 4'h0, 0},
    '{1, 1, 0, 4'hf, 0, KIND_DATA,    4'hf, 1},   // top nibble
    '{1, 1, 0, 4'h0, 0, KIND_DATA,    4'h0, 1},   // bottom nibble
    '{0, 1, 0, 4'ha, 0, KIND_SILENCE, 4'h0, 0},
    '{0, 0, 0, 4'h0, 0, KIND_SILENCE, 4'h0, 0},   // plain end delimiter
    '{0, 0, 0, 4'h0, 0, KIND_SILENCE, 4'h0, 0},   // good end
    '{0, 0, 0, 4'h0, 0, KIND_SILENCE, 4'h0, 0},
    '{0, 1, 1, 4'h5, 0, KIND_SILENCE, 4'h0, 0},   // sync with TX_ER
    '{0, 1, 0, 4'h0, 0, KIND_SILENCE, 4'h0, 0},
    '{0, 1, 0, 4'h0, 0, KIND_SILENCE, 4'h0, 0},
    '{0, 1, 0, 4'h0, 0, KIND_SILENCE, 4'h0, 0},
    '{0, 1, 0, 4'h5, 0, KIND_SILENCE, 4'h0, 0},
    '{0, 0, 1, 4'h3, 0, KIND_SILENCE, 4'h0, 0},   // end with commit -> BRS
    '{1, 0, 0, 4'h0, 0, KIND_ESD_ERR, 4'h0, 1},   // errored frame end
    '{0, 0, 1, 4'hf, 0, KIND_SILENCE, 4'h0, 0},   // silent, odd command
    '{1, 1, 0, 4'h7, 1, KIND_SILENCE, 4'h0, 0},   // PCS reset rising
    '{0, 1, 1, 4'h7, 1, KIND_SILENCE, 4'h0, 0},   // reset held
    '{0, 1, 0, 4'h7, 0, KIND_SILENCE, 4'h0, 0}    // release runs the FSM
  };

  // Limit plans per phase; 0 picks a small random value
  int unsigned max_plan   [NumPhases] = '{65535, 1, 6, 25, 2, 0};
  int unsigned unjab_plan [NumPhases] = '{65535, 1, 3, 40, 65535, 0};

  // DUT ports
  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_idx   = CFG_MAX_FRAME;
  logic [15:0] cfg_wdata = '0;
  logic        s_valid   = 1'b0;
  logic [7:0]  s_data    = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready   = 1'b0;
  logic [7:0]  m_data;
  logic [3:0]  m_user;

  // Run control and bookkeeping
  bit          no_idle   = 1'b0;
  sym_t        sym_pending [$];
  int unsigned n_ticks   = 0;
  int unsigned n_syms    = 0;
  int unsigned n_bad     = 0;
  int unsigned n_frames  = 0;
  int unsigned n_jabs    = 0;
  int unsigned n_cycles  = 0;

  // Predictor state, reset values
  framer_state_e fr_state  = F_SILENT;
  logic          err_seen  = 1'b0;
  logic          tx_on     = 1'b0;
  symbol_kind_e  cur_kind  = KIND_SILENCE;
  logic [3:0]    cur_nib   = '0;
  logic          rst_prev  = 1'b0;
  logic [15:0]   max_cnt   = '0;
  logic          max_run   = 1'b0;
  logic [15:0]   unjab_cnt = '0;
  logic          unjab_run = 1'b0;
  logic [15:0]   lim_max   = 16'hffff;
  logic [15:0]   lim_unjab = 16'hffff;

  pcs_transmit_symbol_fsm_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Beacon and commit only exist with TX_EN low and TX_ER high
  function automatic symbol_kind_e mii_cmd(tick_t t);
    if (!t.en && t.er && t.nib == NibBeacon) return KIND_BEACON;
    if (!t.en && t.er && t.nib == NibCommit) return KIND_COMMIT;
    return KIND_SILENCE;
  endfunction

  // State entry actions; the symbol changes only here, and timers start here
  function automatic void go_state(framer_state_e st, tick_t t);
    fr_state = st;
    cur_nib  = '0;
    case (st)
      F_COMMIT: cur_kind = KIND_COMMIT;
      F_SYNC1: begin
        tx_on    = 1'b1;
        err_seen = err_seen | t.er;
        cur_kind = KIND_SYNC;
        n_frames++;
      end
      F_SYNC2: err_seen = err_seen | t.er;   // symbol stays sync
      F_SSD1: begin
        err_seen = err_seen | t.er;
        cur_kind = KIND_SSD;
      end
      F_SSD2: begin
        err_seen = err_seen | t.er;
        max_cnt  = '0;
        max_run  = 1'b1;
      end
      F_DATA: begin
        err_seen = err_seen | t.er;
        cur_kind = KIND_DATA;
        cur_nib  = t.nib;
      end
      F_ESD: cur_kind = (mii_cmd(t) == KIND_COMMIT) ? KIND_ESD_BRS : KIND_ESD;
      F_BAD_ESD: begin
        cur_kind = err_seen ? KIND_ESD_ERR : KIND_ESD_JAB;
        if (!err_seen) n_jabs++;
      end
      F_GOOD_ESD: cur_kind = KIND_ESD_BRS;
      F_UNJAB: begin
        cur_kind  = KIND_SILENCE;
        unjab_cnt = '0;
        unjab_run = 1'b1;
      end
      default: begin
        fr_state = F_SILENT;
        tx_on    = 1'b0;
        err_seen = 1'b0;
        cur_kind = mii_cmd(t);   // silent re-decodes every tick
      end
    endcase
  endfunction

  // One symbol tick: timers first, then reset edge or FSM step
  function automatic sym_t step_framer(tick_t t);
    logic max_done;
    logic unjab_done;
    sym_t s;
    if (max_run && max_cnt < lim_max) max_cnt++;
    if (unjab_run && unjab_cnt < lim_unjab) unjab_cnt++;
    max_done   = max_run && (max_cnt >= lim_max);
    unjab_done = unjab_run && (unjab_cnt >= lim_unjab);

    if (t.pcs_reset) begin
      // only the rising edge acts; a held reset repeats the last symbol
      if (!rst_prev) begin
        rst_prev  = 1'b1;
        max_cnt   = '0;
        max_run   = 1'b0;
        unjab_cnt = '0;
        unjab_run = 1'b0;
        go_state(F_SILENT, t);
      end
    end else begin
      rst_prev = 1'b0;
      case (fr_state)
        F_COMMIT: begin
          if (t.en) go_state(F_SYNC1, t);
          else if (mii_cmd(t) == KIND_SILENCE) go_state(F_ESD, t);
        end
        F_SYNC1:  go_state(F_SYNC2, t);
        F_SYNC2:  go_state(F_SSD1, t);
        F_SSD1:   go_state(F_SSD2, t);
        F_SSD2:   go_state(F_DATA, t);
        F_DATA: begin
          if (t.en && !max_done) go_state(F_DATA, t);
          else go_state(F_ESD, t);
        end
        F_ESD:    go_state((err_seen || max_done) ? F_BAD_ESD : F_GOOD_ESD, t);
        F_BAD_ESD: begin
          // without an error the jab waits for the max timer
          if (err_seen) go_state(F_SILENT, t);
          else if (max_done) go_state(F_UNJAB, t);
        end
        F_GOOD_ESD: go_state(F_SILENT, t);
        F_UNJAB: begin
          if (!t.en && unjab_done) go_state(F_SILENT, t);
        end
        default: begin
          if (t.en) go_state(F_SYNC1, t);
          else if (mii_cmd(t) == KIND_COMMIT) go_state(F_COMMIT, t);
          else go_state(F_SILENT, t);
        end
      endcase
    end

    s.kind = cur_kind;
    s.nib  = (cur_kind == KIND_DATA) ? cur_nib : 4'h0;
    s.tx   = tx_on;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus side
  // --------------------------------------------------------------------------

  // Send one tick request; the expected symbol is queued on acceptance
  task automatic push_tick(input tick_t t, input bit typed, input sym_t want);
    sym_t pred;
    while (!no_idle && $urandom_range(99) < 35) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {1'b0, t};
    do @(posedge clk_i); while (!s_ready);
    pred = step_framer(t);
    sym_pending.push_back(typed ? want : pred);
    n_ticks++;
  endtask

  // Limit writes only with nothing in flight
  task automatic set_limits(input int unsigned max_v, input int unsigned unjab_v);
    s_valid <= 1'b0;
    while (sym_pending.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MAX_FRAME;
    cfg_wdata <= 16'(max_v);
    @(posedge clk_i);
    cfg_idx   <= CFG_UNJAB;
    cfg_wdata <= 16'(unjab_v);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    lim_max   = 16'(max_v);
    lim_unjab = 16'(unjab_v);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random backpressure and the symbol checker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_ready <= no_idle || ($urandom_range(99) >= 35);
  end

  always @(posedge clk_i) begin
    sym_t want;
    if (rst_ni && m_valid && m_ready) begin
      n_syms++;
      if (sym_pending.size() == 0) begin
        n_bad++;
        if (n_bad <= ReportCap)
          $display("%0t: unexpected symbol kind %0d data %h, none pending",
                   $time, m_user, m_data);
      end else begin
        want = sym_pending.pop_front();
        if (m_user !== want.kind || m_data[3:0] !== want.nib ||
            m_data[4] !== want.tx || m_data[7:5] !== 3'd0) begin
          n_bad++;
          if (n_bad <= ReportCap)
            $display("%0t: symbol mismatch: expected kind %0d nib %h tx %b, got kind %0d data %h",
                     $time, want.kind, want.nib, want.tx, m_user, m_data);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles == CycleLimit) begin
      $display("%0t: timeout with %0d symbols pending", $time, sym_pending.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    tick_t       t;
    sym_t        none;
    int unsigned flen;
    int unsigned tail;
    int unsigned stop_at;
    int unsigned mx;
    int unsigned uj;
    none = '{tx: 1'b0, nib: 4'h0, kind: KIND_SILENCE};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk at the reset limits
    set_limits(65535, 65535);
    foreach (walk[i]) begin
      t = '{pcs_reset: walk[i].rst, nib: walk[i].nib, er: walk[i].er, en: walk[i].en};
      push_tick(t, walk[i].typed,
                '{tx: walk[i].tx, nib: walk[i].dnib, kind: walk[i].kind});
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      mx = (max_plan[ph] == 0) ? $urandom_range(1, 60) : max_plan[ph];
      uj = (unjab_plan[ph] == 0) ? $urandom_range(1, 60) : unjab_plan[ph];
      set_limits(mx, uj);
      no_idle = (ph == 3);   // one long stretch with both sides streaming
      stop_at = n_ticks + PhaseTicks;

      while (n_ticks < stop_at) begin
        if ($urandom_range(99) < 80) begin
          // well-formed frame: idle/beacon, optional commit, data, end
          repeat ($urandom_range(0, 3)) begin
            t.en        = 1'b0;
            t.er        = ($urandom_range(3) == 0);
            t.nib       = $urandom_range(1) ? NibBeacon : 4'($urandom_range(15));
            t.pcs_reset = 1'b0;
            push_tick(t, 1'b0, none);
          end
          if ($urandom_range(1)) begin
            repeat ($urandom_range(1, 3)) begin
              t = '{pcs_reset: 1'b0, nib: NibCommit, er: 1'b1, en: 1'b0};
              push_tick(t, 1'b0, none);
            end
          end
          flen = ($urandom_range(9) == 0) ? $urandom_range(30, 120)
                                          : $urandom_range(1, 30);
          repeat (flen) begin
            t.en        = 1'b1;
            t.er        = ($urandom_range(39) == 0);
            t.nib       = 4'($urandom_range(15));
            t.pcs_reset = 1'b0;
            push_tick(t, 1'b0, none);
          end
          // first tick after TX_EN drops may carry commit for a BRS delimiter
          t.en        = 1'b0;
          t.er        = ($urandom_range(2) == 0);
          t.nib       = t.er ? NibCommit : 4'($urandom_range(15));
          t.pcs_reset = 1'b0;
          push_tick(t, 1'b0, none);
          // tail long enough for the delimiters and a short unjab wait
          tail = $urandom_range(2, 6) + ((lim_unjab <= 100) ? lim_unjab : 0);
          repeat (tail) begin
            t = '{pcs_reset: 1'b0, nib: 4'($urandom_range(15)), er: 1'b0, en: 1'b0};
            push_tick(t, 1'b0, none);
          end
          // a PCS reset pulse now and then; frees a long unjab wait
          if ($urandom_range(9) == 0 ||
              (lim_unjab > 100 && lim_max <= 100 && $urandom_range(2) == 0)) begin
            repeat ($urandom_range(1, 3)) begin
              t           = tick_t'(7'($urandom));
              t.pcs_reset = 1'b1;
              push_tick(t, 1'b0, none);
            end
          end
        end else begin
          // noise: any pattern, reset now and then
          repeat ($urandom_range(1, 8)) begin
            t           = tick_t'(7'($urandom));
            t.pcs_reset = ($urandom_range(7) == 0);
            push_tick(t, 1'b0, none);
          end
        end
      end
    end

    // Drain
    s_valid <= 1'b0;
    no_idle = 1'b0;
    while (sym_pending.size() != 0) @(posedge clk_i);
    repeat (SettleWait * 2) @(posedge clk_i);

    $display("Run: %0d ticks sent, %0d symbols checked, %0d mismatches.",
             n_ticks, n_syms, n_bad);
    $display("Covered %0d frame starts and %0d jabber cutoffs over %0d limit settings.",
             n_frames, n_jabs, NumPhases + 1);
    if (n_bad == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
